FILE: rtl/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package rwhp_pkg;

   // Chunk and file tags, as they sit in a 32-bit shift register after
   // four bytes have been shifted in from the right.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam int MIN_LENGTH   = 44;   // canonical header length
   localparam int FIRST_CHUNK  = 12;   // first chunk header after RIFF/size/WAVE
   localparam int RIFF_TAG_END = 3;    // byte that completes "RIFF"
   localparam int WAVE_TAG_END = 11;   // byte that completes "WAVE"
   localparam int SAMPLE_BITS  = 16;   // only supported sample width

   // Byte places inside an 8-byte chunk header
   localparam int HDR_TAG_END = 3;
   localparam int HDR_SIZE_LO = 4;
   localparam int HDR_SIZE_HI = 7;
   localparam int HDR_BYTES   = 8;

   // Format bytes kept: channels (2), sample rate (4), bits per sample (2)
   localparam int FMT_BYTES = 8;

   localparam int RSP_TDATA_BITS = 136;

   // File offset of format byte lane k
   function automatic int fmt_byte_pos(input int k);
      int pos;
      if (k < 6) begin
         pos = 22 + k;
      end else begin
         pos = 34 + (k - 6);
      end
      return pos;
   endfunction

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_TAG   = 3'd2,
      STATUS_NOT_16BIT = 3'd3,
      STATUS_NO_DATA   = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0] bits_per_sample;
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
   } format_type;

   typedef struct packed {
      logic riff_ok;
      logic wave_ok;
      logic found;
   } snap_flags_type;

endpackage

FILE: rtl/rwhp_parse.sv
// ----------------------------------------------------------------------------
// rwhp_parse
// Input register and per-byte parse state; hands a snapshot on the last byte.
// ----------------------------------------------------------------------------
module rwhp_parse #(
   parameter int POSITION_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_byte,
   input  logic                       req_last,
   output logic                       snap_valid,
   input  logic                       snap_ready,
   output logic [POSITION_BITS-1:0]   snap_len,
   output logic [POSITION_BITS:0]     snap_found_offset,
   output rwhp_pkg::format_type       snap_format,
   output rwhp_pkg::snap_flags_type   snap_flags
);

   localparam int SUM_BITS = ((POSITION_BITS + 1 > 33) ? POSITION_BITS + 1 : 33) + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam int FMT_LANES = rwhp_pkg::FMT_BYTES;

   logic                     in_valid_ff;
   logic [7:0]               byte_ff;
   logic                     last_ff;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS:0]   nhp_ff, nhp_in;
   logic [31:0]              tag_ff, tag_in;
   logic [31:0]              size_ff, size_in;
   logic                     riff_ok_ff, riff_ok_in;
   logic                     wave_ok_ff, wave_ok_in;
   logic                     found_ff, found_in;
   logic [POSITION_BITS:0]   found_off_ff, found_off_in;
   logic [7:0]               fmt_ff [FMT_LANES];
   logic [7:0]               fmt_in [FMT_LANES];

   logic                     s1_move;
   logic                     parse_en;
   logic                     hdr_reached;
   logic [POSITION_BITS:0]   hdr_diff;
   logic                     in_window;
   logic [2:0]               hdr_idx;
   logic [31:0]              size_shifted;
   logic [SUM_BITS-1:0]      nh_sum;
   logic [POSITION_BITS:0]   nh_sat;

   assign s1_move    = in_valid_ff && (!last_ff || snap_ready);
   assign req_tready = !in_valid_ff || s1_move;
   assign parse_en   = (pos_ff != POS_MAX);

   // Window over the 8 header bytes of the chunk being looked at
   assign hdr_reached  = ({1'b0, pos_ff} >= nhp_ff);
   assign hdr_diff     = {1'b0, pos_ff} - nhp_ff;
   assign in_window    = !found_ff && hdr_reached && (hdr_diff[POSITION_BITS:3] == '0);
   assign hdr_idx      = hdr_diff[2:0];
   assign size_shifted = {byte_ff, size_ff[31:8]};

   // Next header: here + 8 + size + pad, held at 2^P when out of range
   assign nh_sum = SUM_BITS'(nhp_ff) + SUM_BITS'(rwhp_pkg::HDR_BYTES)
                 + SUM_BITS'(size_shifted) + SUM_BITS'(size_shifted[0]);
   assign nh_sat = (nh_sum[SUM_BITS-1:POSITION_BITS] != '0)
                 ? {1'b1, {POSITION_BITS{1'b0}}}
                 : {1'b0, nh_sum[POSITION_BITS-1:0]};

   always_comb begin
      pos_in       = pos_ff;
      nhp_in       = nhp_ff;
      tag_in       = tag_ff;
      size_in      = size_ff;
      riff_ok_in   = riff_ok_ff;
      wave_ok_in   = wave_ok_ff;
      found_in     = found_ff;
      found_off_in = found_off_ff;
      for (int k = 0; k < FMT_LANES; k++) begin
         fmt_in[k] = fmt_ff[k];
      end
      if (parse_en) begin
         pos_in = pos_ff + 1'b1;
         tag_in = {tag_ff[23:0], byte_ff};
         if (pos_ff == POSITION_BITS'(rwhp_pkg::RIFF_TAG_END) &&
             tag_in == rwhp_pkg::TAG_RIFF) begin
            riff_ok_in = 1'b1;
         end
         if (pos_ff == POSITION_BITS'(rwhp_pkg::WAVE_TAG_END) &&
             tag_in == rwhp_pkg::TAG_WAVE) begin
            wave_ok_in = 1'b1;
         end
         for (int k = 0; k < FMT_LANES; k++) begin
            if (pos_ff == POSITION_BITS'(rwhp_pkg::fmt_byte_pos(k))) begin
               fmt_in[k] = byte_ff;
            end
         end
         if (in_window) begin
            if (hdr_idx == 3'(rwhp_pkg::HDR_TAG_END) && tag_in == rwhp_pkg::TAG_DATA) begin
               found_in     = 1'b1;
               found_off_in = nhp_ff + (POSITION_BITS + 1)'(rwhp_pkg::HDR_BYTES);
            end else if (hdr_idx >= 3'(rwhp_pkg::HDR_SIZE_LO)) begin
               size_in = size_shifted;
               if (hdr_idx == 3'(rwhp_pkg::HDR_SIZE_HI)) begin
                  nhp_in = nh_sat;
               end
            end
         end
      end
   end

   assign snap_valid        = in_valid_ff && last_ff;
   assign snap_len          = pos_in;
   assign snap_found_offset = found_off_in;
   assign snap_format.channel_count   = {fmt_in[1], fmt_in[0]};
   assign snap_format.sample_rate     = {fmt_in[5], fmt_in[4], fmt_in[3], fmt_in[2]};
   assign snap_format.bits_per_sample = {fmt_in[7], fmt_in[6]};
   assign snap_flags.riff_ok = riff_ok_in;
   assign snap_flags.wave_ok = wave_ok_in;
   assign snap_flags.found   = found_in;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         byte_ff <= req_byte;
         last_ff <= req_last;
      end
   end

   // Parse state; cleared after the last byte, ready for the next file
   always_ff @(posedge clock) begin
      if (reset || (s1_move && last_ff)) begin
         pos_ff       <= '0;
         nhp_ff       <= (POSITION_BITS + 1)'(rwhp_pkg::FIRST_CHUNK);
         tag_ff       <= '0;
         size_ff      <= '0;
         riff_ok_ff   <= 1'b0;
         wave_ok_ff   <= 1'b0;
         found_ff     <= 1'b0;
         found_off_ff <= '0;
         for (int k = 0; k < FMT_LANES; k++) begin
            fmt_ff[k] <= '0;
         end
      end else if (s1_move) begin
         pos_ff       <= pos_in;
         nhp_ff       <= nhp_in;
         tag_ff       <= tag_in;
         size_ff      <= size_in;
         riff_ok_ff   <= riff_ok_in;
         wave_ok_ff   <= wave_ok_in;
         found_ff     <= found_in;
         found_off_ff <= found_off_in;
         for (int k = 0; k < FMT_LANES; k++) begin
            fmt_ff[k] <= fmt_in[k];
         end
      end
   end

endmodule

FILE: rtl/rwhp_result.sv
// ----------------------------------------------------------------------------
// rwhp_result
// Snapshot register, status checks and saturation, result register.
// ----------------------------------------------------------------------------
module rwhp_result #(
   parameter int POSITION_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       snap_valid,
   output logic                       snap_ready,
   input  logic [POSITION_BITS-1:0]   snap_len,
   input  logic [POSITION_BITS:0]     snap_found_offset,
   input  rwhp_pkg::format_type       snap_format,
   input  rwhp_pkg::snap_flags_type   snap_flags,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rwhp_pkg::status_type       rsp_status,
   output rwhp_pkg::format_type       rsp_format,
   output logic [31:0]                rsp_data_offset,
   output logic [30:0]                rsp_sample_count
);

   localparam int EXT_BITS = 64;

   logic                     sv_ff;
   logic [POSITION_BITS-1:0] len_ff;
   logic [POSITION_BITS:0]   foff_ff;
   rwhp_pkg::format_type     fmt_ff;
   rwhp_pkg::snap_flags_type flags_ff;

   logic                     rsp_valid_ff;
   rwhp_pkg::status_type     status_ff, status_in;
   rwhp_pkg::format_type     fmt_out_ff;
   logic [31:0]              off_ff, off_in;
   logic [30:0]              cnt_ff, cnt_in;

   logic                     sv_move;
   logic [POSITION_BITS:0]   rest;
   logic [EXT_BITS-1:0]      off_ext;
   logic [EXT_BITS-1:0]      cnt_ext;

   assign sv_move    = sv_ff && (!rsp_valid_ff || rsp_ready);
   assign snap_ready = !sv_ff || sv_move;

   assign rest    = {1'b0, len_ff} - foff_ff;
   assign off_ext = EXT_BITS'(foff_ff);
   assign cnt_ext = EXT_BITS'(rest[POSITION_BITS:1]);

   always_comb begin
      off_in = '0;
      cnt_in = '0;
      if (len_ff < POSITION_BITS'(rwhp_pkg::MIN_LENGTH)) begin
         status_in = rwhp_pkg::STATUS_SHORT;
      end else if (!(flags_ff.riff_ok && flags_ff.wave_ok)) begin
         status_in = rwhp_pkg::STATUS_BAD_TAG;
      end else if (fmt_ff.bits_per_sample != 16'(rwhp_pkg::SAMPLE_BITS)) begin
         status_in = rwhp_pkg::STATUS_NOT_16BIT;
      end else if (!flags_ff.found || foff_ff >= {1'b0, len_ff}) begin
         status_in = rwhp_pkg::STATUS_NO_DATA;
      end else begin
         status_in = rwhp_pkg::STATUS_OK;
         off_in    = (off_ext[EXT_BITS-1:32] != '0) ? '1 : off_ext[31:0];
         cnt_in    = (cnt_ext[EXT_BITS-1:31] != '0) ? '1 : cnt_ext[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (snap_ready) begin
            sv_ff <= snap_valid;
         end
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= sv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready) begin
         len_ff   <= snap_len;
         foff_ff  <= snap_found_offset;
         fmt_ff   <= snap_format;
         flags_ff <= snap_flags;
      end
      if (sv_move) begin
         status_ff  <= status_in;
         fmt_out_ff <= fmt_ff;
         off_ff     <= off_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_format       = fmt_out_ff;
   assign rsp_data_offset  = off_ff;
   assign rsp_sample_count = cnt_ff;

endmodule

FILE: rtl/riff_wave_header_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Streaming WAV header check: format words, data chunk offset, sample count.
// ----------------------------------------------------------------------------
// Feed a whole WAV file one byte per item, tlast on the final byte; one result
// item comes out per file, and the parser is then ready for the next file at
// once. Bytes go in at one per cycle, sustained, with no gaps between files,
// unless a held result stalls the last byte; the result passes through the
// input register, snapshot register and result register. The per-byte limit is
// the chunk walk in the parse stage: one add of header position, eight, chunk
// size and pad byte, then a range clamp. Status is checked in order: shorter
// than 44 bytes, bad RIFF/WAVE tags, bits per sample not 16, no usable data
// chunk; the first hit wins. Channel count, sample rate and bits per sample are
// reported for any status (bytes never received read as zero); data offset and
// sample count are zero unless the status is ok, and saturate at their field
// widths. Bytes past 2^POSITION_BITS - 1 are counted no further and not parsed.
// ----------------------------------------------------------------------------
module riff_wave_header_parser #(
   parameter int POSITION_BITS = 32   // byte position width, 16 to 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] file_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [18:3] channel_count, [50:19] sample_rate,
   // [66:51] bits_per_sample, [98:67] data_offset, [129:99] sample_count,
   // [135:130] zero
   output logic [rwhp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   // Parse stage to result stage
   logic                     snap_valid;
   logic                     snap_ready;
   logic [POSITION_BITS-1:0] snap_len;
   logic [POSITION_BITS:0]   snap_found_offset;
   rwhp_pkg::format_type     snap_format;
   rwhp_pkg::snap_flags_type snap_flags;

   // Result register contents
   rwhp_pkg::status_type     rsp_status;
   rwhp_pkg::format_type     rsp_format;
   logic [31:0]              rsp_data_offset;
   logic [30:0]              rsp_sample_count;

   // Per-byte parse: tags, format bytes, chunk walk
   rwhp_parse #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parse (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_byte          (req_tdata),
      .req_last          (req_tlast),
      .snap_valid        (snap_valid),
      .snap_ready        (snap_ready),
      .snap_len          (snap_len),
      .snap_found_offset (snap_found_offset),
      .snap_format       (snap_format),
      .snap_flags        (snap_flags)
   );

   // End-of-file checks and output register
   rwhp_result #(
      .POSITION_BITS (POSITION_BITS)
   ) u_result (
      .clock             (clock),
      .reset             (reset),
      .snap_valid        (snap_valid),
      .snap_ready        (snap_ready),
      .snap_len          (snap_len),
      .snap_found_offset (snap_found_offset),
      .snap_format       (snap_format),
      .snap_flags        (snap_flags),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_format        (rsp_format),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_sample_count  (rsp_sample_count)
   );

   assign rsp_tdata = {6'b0,
                       rsp_sample_count,
                       rsp_data_offset,
                       rsp_format.bits_per_sample,
                       rsp_format.sample_rate,
                       rsp_format.channel_count,
                       rsp_status};

endmodule
